### sv/antialiased_line_rasterizer_defines.svh
// Assertion macros shared by the rasterizer's checker.
// Needs a clk and an arst_n in the scope where the macros are used.
`ifndef ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH
`define ANTIALIASED_LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define ALR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define ALR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/alr_pkg.sv
// Shared types and constants of the antialiased line rasterizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package alr_pkg;

	localparam int CH_BITS    = 8;
	localparam int NUM_CH     = 3;
	localparam int COLOR_BITS = CH_BITS * NUM_CH;
	localparam int ARGB_BITS  = COLOR_BITS + CH_BITS;
	localparam logic [CH_BITS-1:0] ALPHA_OPAQUE = 8'hff;

	localparam int DIM_BITS      = 12;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 24;

	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_BACKGROUND   = 2'd2;

	localparam logic [DIM_BITS-1:0]   RST_FRAME_WIDTH  = 12'd640;
	localparam logic [DIM_BITS-1:0]   RST_FRAME_HEIGHT = 12'd480;
	localparam logic [COLOR_BITS-1:0] RST_BACKGROUND   = 24'd0;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_DIVIDE
	} alr_state_t;

endpackage

`default_nettype wire

### sv/alr_div.sv
// Shared restoring divider: one quotient bit per cycle.
// Depends on alr_pkg (imported for the house style; no package items needed beyond it).
`default_nettype none

module alr_div
	import alr_pkg::*;
#(
	parameter int DIVIDEND_BITS = 32,
	parameter int DIVISOR_BITS  = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire  [DIVIDEND_BITS-1:0] dividend,
	input  wire  [DIVISOR_BITS-1:0]  divisor,
	output logic [DIVIDEND_BITS-1:0] quotient,
	output logic                     done
);

	localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

	logic [CNT_W-1:0]         cnt_q;
	logic [DIVISOR_BITS-1:0]  rem_q;
	logic [DIVISOR_BITS-1:0]  dvs_q;
	logic [DIVIDEND_BITS-1:0] quo_q;
	logic                     done_q;

	logic [DIVISOR_BITS:0] shifted;
	logic [DIVISOR_BITS:0] trial;
	logic                  fits;

	// One trial subtraction per cycle: the shared unit.
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_BITS-1]};
		trial   = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(DIVIDEND_BITS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? trial[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
			quo_q <= {quo_q[DIVIDEND_BITS-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

`default_nettype wire

### sv/alr_pix.sv
// Column pixel unit: splits y into row and fraction, blends both pixels, clips.
// Depends on alr_pkg for channel widths and the alpha constant.
`default_nettype none

module alr_pix
	import alr_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire  signed [COORD_BITS-1:0]           column,
	input  wire  signed [COORD_BITS-1:0]           stop,
	input  wire  signed [COORD_BITS+FRAC_BITS:0]   acc,
	input  wire         [COLOR_BITS-1:0]           line_color,
	input  wire         [COLOR_BITS-1:0]           background,
	input  wire         [DIM_BITS-1:0]             frame_width,
	input  wire         [DIM_BITS-1:0]             frame_height,
	output logic signed [COORD_BITS-1:0]           upper_y,
	output logic        [ARGB_BITS-1:0]            upper_color,
	output logic                                   upper_valid,
	output logic signed [COORD_BITS-1:0]           lower_y,
	output logic        [ARGB_BITS-1:0]            lower_color,
	output logic                                   lower_valid,
	output logic                                   last
);

	localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
	localparam int YI_W  = ACC_W - FRAC_BITS;
	localparam int CMP_W = (COORD_BITS + 2 > DIM_BITS + 1) ? COORD_BITS + 2 : DIM_BITS + 1;
	localparam int NUM_W = FRAC_BITS + CH_BITS + 2;

	logic signed [YI_W-1:0]       yi;
	logic signed [YI_W:0]         y2;
	logic        [FRAC_BITS-1:0]  frac;
	logic signed [CMP_W-1:0]      x_c, yu_c, yl_c, w_c, h_c;
	logic signed [COORD_BITS:0]   next_col;
	logic        [COLOR_BITS-1:0] up_rgb, lo_rgb;

	// Floor is the arithmetic shift; the fraction is what it drops.
	assign yi   = acc[ACC_W-1:FRAC_BITS];
	assign frac = acc[FRAC_BITS-1:0];
	assign y2   = (YI_W+1)'(yi) + (YI_W+1)'(1);

	assign upper_y = yi[COORD_BITS-1:0];
	assign lower_y = y2[COORD_BITS-1:0];

	// Clip on unwrapped rows so an overflowing lower row reads as outside.
	always_comb begin
		x_c  = CMP_W'(column);
		yu_c = CMP_W'(yi);
		yl_c = CMP_W'(y2);
		w_c  = CMP_W'({1'b0, frame_width});
		h_c  = CMP_W'({1'b0, frame_height});
		upper_valid = (x_c >= 0) && (x_c < w_c) && (yu_c >= 0) && (yu_c < h_c);
		lower_valid = (x_c >= 0) && (x_c < w_c) && (yl_c >= 0) && (yl_c < h_c);
	end

	assign next_col = (COORD_BITS+1)'(column) + (COORD_BITS+1)'(1);
	assign last     = (next_col == (COORD_BITS+1)'(stop));

	// Upper: c + (b-c)*frac; lower: b - (b-c)*frac. One product per channel.
	for (genvar g = 0; g < NUM_CH; g++) begin : g_ch
		logic signed [NUM_W-1:0] c_ext, b_ext, diff, w_ext, prod, up_num, lo_num;

		assign c_ext  = NUM_W'({1'b0, line_color[g*CH_BITS +: CH_BITS]});
		assign b_ext  = NUM_W'({1'b0, background[g*CH_BITS +: CH_BITS]});
		assign diff   = b_ext - c_ext;
		assign w_ext  = NUM_W'({1'b0, frac});
		assign prod   = diff * w_ext;
		assign up_num = (c_ext <<< FRAC_BITS) + prod;
		assign lo_num = (b_ext <<< FRAC_BITS) - prod;

		assign up_rgb[g*CH_BITS +: CH_BITS] = up_num[FRAC_BITS +: CH_BITS];
		assign lo_rgb[g*CH_BITS +: CH_BITS] = lo_num[FRAC_BITS +: CH_BITS];
	end

	assign upper_color = {ALPHA_OPAQUE, up_rgb};
	assign lower_color = {ALPHA_OPAQUE, lo_rgb};

endmodule

`default_nettype wire

### sv/antialiased_line_rasterizer.sv
// Antialiased line rasterizer (shallow lines): top level with sequencer and state.
// Depends on alr_pkg, alr_div (slope divider) and alr_pix (column pixel unit).
//
// Usage:
//  - Item channel (item_valid / item_stall): func = FUNC_LOAD latches two
//    endpoints and a colour; func = FUNC_STEP asks for the next column.
//  - Result channel (result_valid / result_stall): one result per step while
//    a line is active, carrying the column's two pixel writes and a last flag.
//  - Config port (wr_en / wr_index / wr_data): frame width, frame height and
//    background colour; write only while the block is idle.
//  - A load with distinct x runs the slope division on the shared divider,
//    one quotient bit per cycle: item_stall stays high after the load is
//    accepted until the division is done.
//    A load with equal x ends the line at once and stalls nothing.
//  - Once a step is accepted, its result sits in the output register
//    from the next cycle, so steps stream one per cycle while the receiver
//    takes them.
//  - While a result waits under result_stall, item_stall is high and the
//    result holds unchanged.
//  - Reset clears the line's active flag, the result valid flag and the
//    sequencer; the config registers go to 640 x 480, black background.
`default_nettype none

module antialiased_line_rasterizer
	import alr_pkg::*;
#(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          wr_en,
	input  wire  [CFG_IDX_BITS-1:0]      wr_index,
	input  wire  [CFG_DATA_BITS-1:0]     wr_data,
	input  wire                          item_valid,
	output logic                         item_stall,
	input  wire                          func,
	input  wire  signed [COORD_BITS-1:0] start_x,
	input  wire  signed [COORD_BITS-1:0] start_y,
	input  wire  signed [COORD_BITS-1:0] end_x,
	input  wire  signed [COORD_BITS-1:0] end_y,
	input  wire  [COLOR_BITS-1:0]        line_color,
	output logic                         result_valid,
	input  wire                          result_stall,
	output logic signed [COORD_BITS-1:0] column_x,
	output logic signed [COORD_BITS-1:0] upper_y,
	output logic [ARGB_BITS-1:0]         upper_color,
	output logic                         upper_valid,
	output logic signed [COORD_BITS-1:0] lower_y,
	output logic [ARGB_BITS-1:0]         lower_color,
	output logic                         lower_valid,
	output logic                         last
);

	localparam int ACC_W   = COORD_BITS + FRAC_BITS + 1;
	localparam int SLOPE_W = COORD_BITS + FRAC_BITS + 1;
	localparam int QUO_W   = COORD_BITS + FRAC_BITS;

	// Configuration registers.
	logic [DIM_BITS-1:0]   frame_width_q;
	logic [DIM_BITS-1:0]   frame_height_q;
	logic [COLOR_BITS-1:0] background_q;

	// Line state.
	logic signed [COORD_BITS-1:0] current_q;
	logic signed [COORD_BITS-1:0] stop_q;
	logic signed [SLOPE_W-1:0]    slope_q;
	logic signed [ACC_W-1:0]      acc_q;
	logic [COLOR_BITS-1:0]        held_color_q;
	logic                         active_q;
	logic                         neg_q;

	alr_state_t state_q, state_d;

	// Output register.
	logic                         result_valid_q;
	logic signed [COORD_BITS-1:0] column_x_q, upper_y_q, lower_y_q;
	logic [ARGB_BITS-1:0]         upper_color_q, lower_color_q;
	logic                         upper_valid_q, lower_valid_q, last_q;

	logic item_fire, load_fire, step_fire, div_start, div_done;

	// Load datapath: order the endpoints by x, form |dy| << F and dx.
	logic                         swap;
	logic signed [COORD_BITS-1:0] xl, yl, xr, yr;
	logic signed [COORD_BITS:0]   dx, dy, dy_mag;
	logic [QUO_W-1:0]             dividend, quotient;

	// Column unit outputs.
	logic signed [COORD_BITS-1:0] px_upper_y, px_lower_y;
	logic [ARGB_BITS-1:0]         px_upper_color, px_lower_color;
	logic                         px_upper_valid, px_lower_valid, px_last;

	assign item_fire = item_valid && !item_stall;
	assign load_fire = item_fire && (func == FUNC_LOAD);
	assign step_fire = item_fire && (func == FUNC_STEP) && active_q;

	always_comb begin
		swap     = start_x > end_x;
		xl       = swap ? end_x   : start_x;
		yl       = swap ? end_y   : start_y;
		xr       = swap ? start_x : end_x;
		yr       = swap ? start_y : end_y;
		dx       = (COORD_BITS+1)'(xr) - (COORD_BITS+1)'(xl);
		dy       = (COORD_BITS+1)'(yr) - (COORD_BITS+1)'(yl);
		dy_mag   = dy[COORD_BITS] ? -dy : dy;
		dividend = {dy_mag[COORD_BITS-1:0], {FRAC_BITS{1'b0}}};
	end

	// Sequencer: idle, or divide while the slope is worked out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = result_valid_q && result_stall;
				if (load_fire && (dx != '0)) begin
					div_start = 1'b1;
					state_d   = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	alr_div #(
		.DIVIDEND_BITS(QUO_W),
		.DIVISOR_BITS (COORD_BITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(dividend),
		.divisor (dx[COORD_BITS-1:0]),
		.quotient(quotient),
		.done    (div_done)
	);

	alr_pix #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_pix (
		.column      (current_q),
		.stop        (stop_q),
		.acc         (acc_q),
		.line_color  (held_color_q),
		.background  (background_q),
		.frame_width (frame_width_q),
		.frame_height(frame_height_q),
		.upper_y     (px_upper_y),
		.upper_color (px_upper_color),
		.upper_valid (px_upper_valid),
		.lower_y     (px_lower_y),
		.lower_color (px_lower_color),
		.lower_valid (px_lower_valid),
		.last        (px_last)
	);

	// Config writes; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
			background_q   <= RST_BACKGROUND;
		end else if (wr_en) begin
			case (wr_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= wr_data[DIM_BITS-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= wr_data[DIM_BITS-1:0];
				CFG_BACKGROUND:   background_q   <= wr_data[COLOR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Line active flag: drop on a load, raise once the slope lands, drop after the last column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load_fire) begin
			active_q <= 1'b0;
		end else if (state_q == ST_DIVIDE && div_done) begin
			active_q <= 1'b1;
		end else if (step_fire) begin
			active_q <= !px_last;
		end
	end

	// Line payload: latch on load, take the slope when the divide ends, advance on each step.
	always_ff @(posedge clk) begin
		if (load_fire) begin
			current_q    <= xl;
			stop_q       <= xr;
			held_color_q <= line_color;
			acc_q        <= ACC_W'(yl) <<< FRAC_BITS;
			neg_q        <= dy[COORD_BITS];
			slope_q      <= '0;
		end else if (state_q == ST_DIVIDE && div_done) begin
			slope_q <= neg_q ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
		end else if (step_fire) begin
			current_q <= current_q + COORD_BITS'(1);
			acc_q     <= acc_q + slope_q;
		end
	end

	// Output register: fill on a step, empty when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (step_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_fire) begin
			column_x_q    <= current_q;
			upper_y_q     <= px_upper_y;
			upper_color_q <= px_upper_color;
			upper_valid_q <= px_upper_valid;
			lower_y_q     <= px_lower_y;
			lower_color_q <= px_lower_color;
			lower_valid_q <= px_lower_valid;
			last_q        <= px_last;
		end
	end

	assign result_valid = result_valid_q;
	assign column_x     = column_x_q;
	assign upper_y      = upper_y_q;
	assign upper_color  = upper_color_q;
	assign upper_valid  = upper_valid_q;
	assign lower_y      = lower_y_q;
	assign lower_color  = lower_color_q;
	assign lower_valid  = lower_valid_q;
	assign last         = last_q;

endmodule

`default_nettype wire

### sv/alr_checker.sv
// Port-level checker of the antialiased line rasterizer, bound to the top level.
// Depends on alr_pkg and antialiased_line_rasterizer_defines.svh.
`default_nettype none

`include "antialiased_line_rasterizer_defines.svh"

module alr_checker
	import alr_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          item_valid,
	input wire                          item_stall,
	input wire                          func,
	input wire  signed [COORD_BITS-1:0] start_x,
	input wire  signed [COORD_BITS-1:0] end_x,
	input wire                          result_valid,
	input wire                          result_stall,
	input wire  signed [COORD_BITS-1:0] column_x,
	input wire  [ARGB_BITS-1:0]         upper_color
);

	`ALR_ASSERT_NEXT(a_result_holds, result_valid && result_stall, result_valid && $stable(column_x) && $stable(upper_color), "stalled result changed")

	`ALR_ASSERT_NOW(a_wait_blocks_items, result_valid && result_stall, item_stall, "item taken while a result waits")

	`ALR_ASSERT_NEXT(a_load_no_result, item_valid && !item_stall && func == FUNC_LOAD && !result_valid, !result_valid, "load produced a result")

	`ALR_ASSERT_NEXT(a_load_divides, item_valid && !item_stall && func == FUNC_LOAD && start_x != end_x, item_stall, "load with distinct x did not start the divide")

endmodule

bind antialiased_line_rasterizer alr_checker #(.COORD_BITS(COORD_BITS)) u_alr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item_valid),
	.item_stall  (item_stall),
	.func        (func),
	.start_x     (start_x),
	.end_x       (end_x),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.column_x    (column_x),
	.upper_color (upper_color)
);

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the antialiased line rasterizer.
// Depends on alr_pkg and antialiased_line_rasterizer; models the block in place.

module testbench;
	import alr_pkg::*;

	localparam int COORD_W = 16;
	localparam int FRAC_W = 16;
	localparam logic [FRAC_W:0] FRAC_ONE = 1 << FRAC_W;
	// The slope divider keeps the block busy this long after a load.
	localparam int DIV_CYCLES = COORD_W + FRAC_W + 1;
	localparam int SETTLE_CYCLES = DIV_CYCLES + 8;
	localparam int IDLE_LIMIT = 2000;
	localparam int PHASE_ITEMS = 116;
	localparam int NUM_PHASES = 6;

	typedef struct packed {
		logic                func;
		logic [COORD_W-1:0]  sx;
		logic [COORD_W-1:0]  sy;
		logic [COORD_W-1:0]  ex;
		logic [COORD_W-1:0]  ey;
		logic [COLOR_BITS-1:0] color;
	} line_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]   column_x;
		logic [COORD_W-1:0]   upper_y;
		logic [ARGB_BITS-1:0] upper_color;
		logic                 upper_valid;
		logic [COORD_W-1:0]   lower_y;
		logic [ARGB_BITS-1:0] lower_color;
		logic                 lower_valid;
		logic                 last;
	} pixel_pair_t;

	typedef struct {
		line_item_t  it;
		bit          typed;
		bit          present;
		pixel_pair_t want;
	} dir_row_t;

	typedef enum {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} rx_mode_t;

	// Block inputs, known from time zero.
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0]     wr_index = '0;
	logic [CFG_DATA_BITS-1:0]    wr_data = '0;
	logic                        item_valid = 1'b0;
	logic                        func = FUNC_STEP;
	logic signed [COORD_W-1:0]   start_x = '0;
	logic signed [COORD_W-1:0]   start_y = '0;
	logic signed [COORD_W-1:0]   end_x = '0;
	logic signed [COORD_W-1:0]   end_y = '0;
	logic [COLOR_BITS-1:0]       line_color = '0;
	logic                        result_stall = 1'b0;

	// Block outputs.
	logic                        item_stall;
	logic                        result_valid;
	logic signed [COORD_W-1:0]   column_x;
	logic signed [COORD_W-1:0]   upper_y;
	logic [ARGB_BITS-1:0]        upper_color;
	logic                        upper_valid;
	logic signed [COORD_W-1:0]   lower_y;
	logic [ARGB_BITS-1:0]        lower_color;
	logic                        lower_valid;
	logic                        last;

	// Model copy of the config registers.
	logic [DIM_BITS-1:0]         frame_w = RST_FRAME_WIDTH;
	logic [DIM_BITS-1:0]         frame_h = RST_FRAME_HEIGHT;
	logic [COLOR_BITS-1:0]       backdrop = RST_BACKGROUND;

	// Model copy of the line walker.
	int                          col_now = 0;
	int                          col_stop = 0;
	logic signed [47:0]          y_slope = '0;
	logic signed [47:0]          y_acc = '0;
	logic [COLOR_BITS-1:0]       held_rgb = '0;
	bit                          line_on = 1'b0;

	pixel_pair_t                 pixel_writes_due[$];
	dir_row_t                    dir_rows[$];
	int                          error_count = 0;
	int                          items_done = 0;
	int                          burst_left = 0;
	int                          idle_cycles = 0;
	rx_mode_t                    rx_mode = RX_FREE;
	int                          rx_left = 0;

	antialiased_line_rasterizer #(
		.COORD_BITS(COORD_W),
		.FRAC_BITS(FRAC_W)
	) i_dut (.*);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Weight w pulls each channel from fg toward bg; alpha is always opaque.
	function automatic logic [ARGB_BITS-1:0] blend_toward(input logic [COLOR_BITS-1:0] fg,
			input logic [COLOR_BITS-1:0] bg, input logic [FRAC_W:0] w);
		logic [ARGB_BITS-1:0] mix;
		logic [47:0]          num;
		mix = '0;
		mix[ARGB_BITS-1 -: CH_BITS] = ALPHA_OPAQUE;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			num = 48'(fg[ch*CH_BITS +: CH_BITS]) * 48'(FRAC_ONE - w)
				+ 48'(bg[ch*CH_BITS +: CH_BITS]) * 48'(w);
			mix[ch*CH_BITS +: CH_BITS] = num[FRAC_W +: CH_BITS];
		end
		return mix;
	endfunction

	function automatic bit on_frame(input int x, input int y);
		return x >= 0 && x < int'(frame_w) && y >= 0 && y < int'(frame_h);
	endfunction

	// Advance the line model by one accepted item; got flags a column result.
	task automatic rasterize_item(input line_item_t it, output bit got, output pixel_pair_t pp);
		int          x1, y1, x2, y2, xl, yl, xr, yr, dy, yi, y_next;
		logic [47:0] mag, quo;
		logic [FRAC_W:0] frac;
		got = 1'b0;
		pp = '0;
		if (it.func == FUNC_LOAD) begin
			x1 = $signed(it.sx);
			y1 = $signed(it.sy);
			x2 = $signed(it.ex);
			y2 = $signed(it.ey);
			xl = x1;
			yl = y1;
			xr = x2;
			yr = y2;
			// Walk from the endpoint with the smaller x.
			if (x1 > x2) begin
				xl = x2;
				yl = y2;
				xr = x1;
				yr = y1;
			end
			held_rgb = it.color;
			col_now = xl;
			col_stop = xr;
			y_acc = 48'(yl) << FRAC_W;
			if (xl == xr) begin
				// Equal x: no line, later steps fall through.
				y_slope = '0;
				line_on = 1'b0;
			end else begin
				dy = yr - yl;
				mag = 48'(dy < 0 ? -dy : dy) << FRAC_W;
				quo = mag / 48'(xr - xl);
				y_slope = (dy < 0) ? -$signed(quo) : $signed(quo);
				line_on = 1'b1;
			end
		end else if (line_on) begin
			// Arithmetic shift floors toward minus infinity; frac is what remains.
			yi = int'(y_acc >>> FRAC_W);
			frac = {1'b0, y_acc[FRAC_W-1:0]};
			y_next = yi + 1;
			pp.column_x = col_now[COORD_W-1:0];
			pp.upper_y = yi[COORD_W-1:0];
			pp.upper_color = blend_toward(held_rgb, backdrop, frac);
			pp.upper_valid = on_frame(col_now, yi);
			// Lower row wraps in the field but is judged unwrapped.
			pp.lower_y = y_next[COORD_W-1:0];
			pp.lower_color = blend_toward(held_rgb, backdrop, FRAC_ONE - frac);
			pp.lower_valid = on_frame(col_now, y_next);
			pp.last = (col_now + 1 == col_stop);
			col_now++;
			y_acc += y_slope;
			if (col_now >= col_stop)
				line_on = 1'b0;
			got = 1'b1;
		end
	endtask

	function automatic line_item_t mk_load(input int sx, input int sy, input int ex, input int ey,
			input logic [COLOR_BITS-1:0] c);
		line_item_t it;
		it.func = FUNC_LOAD;
		it.sx = COORD_W'(sx);
		it.sy = COORD_W'(sy);
		it.ex = COORD_W'(ex);
		it.ey = COORD_W'(ey);
		it.color = c;
		return it;
	endfunction

	// Steps carry random payload; the block must ignore it.
	function automatic line_item_t mk_step();
		line_item_t it;
		it.func = FUNC_STEP;
		it.sx = COORD_W'($urandom);
		it.sy = COORD_W'($urandom);
		it.ex = COORD_W'($urandom);
		it.ey = COORD_W'($urandom);
		it.color = COLOR_BITS'($urandom);
		return it;
	endfunction

	function automatic pixel_pair_t pair_of(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] uy, input logic [COLOR_BITS-1:0] uc, input logic uv,
			input logic [COORD_W-1:0] ly, input logic [COLOR_BITS-1:0] lc, input logic lv,
			input logic lst);
		pixel_pair_t pp;
		pp.column_x = x;
		pp.upper_y = uy;
		pp.upper_color = {ALPHA_OPAQUE, uc};
		pp.upper_valid = uv;
		pp.lower_y = ly;
		pp.lower_color = {ALPHA_OPAQUE, lc};
		pp.lower_valid = lv;
		pp.last = lst;
		return pp;
	endfunction

	task automatic add_row(input line_item_t it, input bit typed = 1'b0,
			input bit present = 1'b0, input pixel_pair_t want = '0);
		dir_row_t row;
		row.it = it;
		row.typed = typed;
		row.present = present;
		row.want = want;
		dir_rows.push_back(row);
	endtask

	// Present one item and hold it until accepted. Bursts end in a random gap.
	task automatic send_item(input line_item_t it);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			item_valid = 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		item_valid = 1'b1;
		func = it.func;
		start_x = it.sx;
		start_y = it.sy;
		end_x = it.ex;
		end_y = it.ey;
		line_color = it.color;
		do @(posedge clk); while (item_stall);
		burst_left--;
	endtask

	// Send, predict at the accepting edge, queue the expected column.
	task automatic issue(input line_item_t it);
		bit          got;
		pixel_pair_t pp;
		send_item(it);
		rasterize_item(it, got, pp);
		if (got)
			pixel_writes_due.push_back(pp);
		if (it.func == FUNC_LOAD || got)
			items_done++;
	endtask

	// Drop valid, wait out every due column, then hold for extra cycles.
	task automatic drain_results(input int extra);
		@(negedge clk);
		item_valid = 1'b0;
		burst_left = 0;
		while (pixel_writes_due.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(posedge clk);
		case (idx)
			CFG_FRAME_WIDTH:  frame_w = data[DIM_BITS-1:0];
			CFG_FRAME_HEIGHT: frame_h = data[DIM_BITS-1:0];
			CFG_BACKGROUND:   backdrop = data[COLOR_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en = 1'b0;
	endtask

	task automatic set_frame(input int w, input int h, input logic [COLOR_BITS-1:0] bg);
		write_reg(CFG_FRAME_WIDTH, CFG_DATA_BITS'(w));
		write_reg(CFG_FRAME_HEIGHT, CFG_DATA_BITS'(h));
		write_reg(CFG_BACKGROUND, bg);
	endtask

	// Mostly complete lines near the frame, plus wild loads, equal-x loads and loose steps.
	task automatic run_phase(input int target);
		int first, pick, dx, span, dy, xl, yl, xr, yr, steps, xs;
		bit paused;
		logic [COLOR_BITS-1:0] c;
		first = items_done;
		paused = 1'b0;
		while (items_done - first < target) begin
			// Once per phase, let the pipe run dry with the sender held off.
			if (!paused && items_done - first >= target / 2) begin
				drain_results(0);
				paused = 1'b1;
			end
			pick = $urandom_range(0, 99);
			c = COLOR_BITS'($urandom);
			if (pick < 70) begin
				dx = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
				span = ($urandom_range(0, 4) == 0) ? dx * 6 : dx;
				dy = int'($urandom_range(0, 2 * span)) - span;
				xl = int'($urandom_range(0, 716)) - 16;
				yl = int'($urandom_range(0, 536)) - 16;
				xr = xl + dx;
				yr = yl + dy;
				if ($urandom_range(0, 1))
					issue(mk_load(xl, yl, xr, yr, c));
				else
					issue(mk_load(xr, yr, xl, yl, c));
				steps = dx;
				pick = $urandom_range(0, 99);
				if (pick < 15)
					steps = $urandom_range(0, dx - 1);
				else if (pick < 30)
					steps = dx + $urandom_range(1, 3);
				repeat (steps) issue(mk_step());
			end else if (pick < 80) begin
				issue(mk_load($urandom, $urandom, $urandom, $urandom, c));
				repeat ($urandom_range(1, 4)) issue(mk_step());
			end else if (pick < 88) begin
				xs = $urandom;
				issue(mk_load(xs, $urandom, xs, $urandom, c));
				issue(mk_step());
			end else begin
				repeat ($urandom_range(1, 3)) issue(mk_step());
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// Receiver: stall in one of four modes, picked anew at random intervals.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(5, 60);
		end
		rx_left--;
		case (rx_mode)
			RX_FREE:   result_stall = 1'b0;
			RX_COIN:   result_stall = $urandom_range(0, 1);
			RX_SPARSE: result_stall = ($urandom_range(0, 7) == 0);
			RX_BURSTY: result_stall = (rx_left % 16) < 10;
			default:   result_stall = 1'b0;
		endcase
	end

	// Compare every accepted column with the oldest expectation.
	always @(posedge clk) begin
		pixel_pair_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pixel_writes_due.size() == 0) begin
				$error("column result with no item waiting, column_x %0h", column_x);
				error_count++;
			end else begin
				want = pixel_writes_due.pop_front();
				check_field("column_x", want.column_x, $unsigned(column_x));
				check_field("upper_y", want.upper_y, $unsigned(upper_y));
				check_field("upper_color", want.upper_color, upper_color);
				check_field("upper_valid", want.upper_valid, upper_valid);
				check_field("lower_y", want.lower_y, $unsigned(lower_y));
				check_field("lower_color", want.lower_color, lower_color);
				check_field("lower_valid", want.lower_valid, lower_valid);
				check_field("last", want.last, last);
			end
		end
	end

	// Watchdog: too long without any item moving on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		bit          got;
		pixel_pair_t pp;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Step with nothing loaded after reset: no column.
		add_row(mk_step(), 1'b1, 1'b0);
		// Flat white line at the origin, black background after reset.
		add_row(mk_load(0, 0, 3, 0, 24'hffffff));
		add_row(mk_step(), 1'b1, 1'b1,
			pair_of(16'd0, 16'd0, 24'hffffff, 1'b1, 16'd1, 24'h000000, 1'b1, 1'b0));
		add_row(mk_step());
		add_row(mk_step(), 1'b1, 1'b1,
			pair_of(16'd2, 16'd0, 24'hffffff, 1'b1, 16'd1, 24'h000000, 1'b1, 1'b1));
		// Past the end of the line: ignored.
		add_row(mk_step(), 1'b1, 1'b0);
		// Equal x makes no line.
		add_row(mk_load(5, 5, 5, 9, 24'h00ff00));
		add_row(mk_step(), 1'b1, 1'b0);
		// Right-to-left endpoints, falling slope.
		add_row(mk_load(10, 4, 2, 20, 24'h123456));
		add_row(mk_step());
		// Coordinate extremes replace the active line; everything off frame.
		add_row(mk_load(-32768, -32768, 32767, 32767, 24'h000000));
		add_row(mk_step(), 1'b1, 1'b1,
			pair_of(16'h8000, 16'h8000, 24'h000000, 1'b0, 16'h8001, 24'h000000, 1'b0, 1'b0));
		add_row(mk_load(-32768, 32767, 32767, -32768, 24'hffffff));
		add_row(mk_step());
		// Lower row past the top of the field wraps and is flagged off frame.
		add_row(mk_load(0, 32767, 2, 32767, 24'hffffff));
		add_row(mk_step(), 1'b1, 1'b1,
			pair_of(16'd0, 16'h7fff, 24'hffffff, 1'b0, 16'h8000, 24'h000000, 1'b0, 1'b0));
		// Steep line still gives one column per x.
		add_row(mk_load(0, 0, 1, 1000, 24'h808080));
		add_row(mk_step());
		// Right and bottom frame edges.
		add_row(mk_load(638, 479, 641, 479, 24'hff0000));
		add_row(mk_step());
		add_row(mk_step());
		add_row(mk_step());
		// Negative y with a fraction; left running across the register change.
		add_row(mk_load(0, -1, 30, 9, 24'h0000ff));
		add_row(mk_step());
		add_row(mk_step());

		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].it);
			rasterize_item(dir_rows[i].it, got, pp);
			if (dir_rows[i].typed) begin
				if (dir_rows[i].present)
					pixel_writes_due.push_back(dir_rows[i].want);
			end else if (got) begin
				pixel_writes_due.push_back(pp);
			end
		end

		// Each phase starts from an idle block with fresh register settings.
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain_results(SETTLE_CYCLES);
			case (p)
				0: set_frame(4095, 4095, 24'hffffff);
				1: set_frame(1, 1, 24'h000000);
				2: set_frame(0, $urandom_range(1, 4095), COLOR_BITS'($urandom));
				3: set_frame(640, 480, COLOR_BITS'($urandom));
				4: set_frame($urandom_range(1, 4095), $urandom_range(1, 4095),
					COLOR_BITS'($urandom));
				default: set_frame(64, 32, COLOR_BITS'($urandom));
			endcase
			run_phase(PHASE_ITEMS);
		end

		drain_results(SETTLE_CYCLES);
		if (error_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
